// ----- rtl/artc_pkg.sv -----
// ----------------------------------------------------------------------------
// artc_pkg
// Shared codes and types for the range table check block.
// ----------------------------------------------------------------------------
package artc_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_COVER  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [1:0] KIND_SINGLE  = 2'd0;
    localparam logic [1:0] KIND_RANGE   = 2'd1;
    localparam logic [1:0] KIND_INHERIT = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_INHERIT = 2'd1;
    localparam logic [1:0] ERR_OVERLAP = 2'd2;
    localparam logic [1:0] ERR_FULL    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] low;
        logic [31:0] high;
    } t_entry;

    typedef struct packed {
        logic       accepted;
        logic [1:0] error_code;
        logic       covered;
    } t_rsp;

endpackage

// ----- rtl/artc_req_if.sv -----
// ----------------------------------------------------------------------------
// artc_req_if
// Request channel: valid/ready handshake with one table request per item.
// ----------------------------------------------------------------------------
interface artc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [1:0]  entry_kind;
    logic [31:0] num_low;
    logic [31:0] num_high;

    modport source (
        output valid, req_type, entry_kind, num_low, num_high,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_kind, num_low, num_high,
        output ready
    );
endinterface

// ----- rtl/artc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// artc_rsp_if
// Response channel: valid/ready handshake with one result per item.
// ----------------------------------------------------------------------------
interface artc_rsp_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [1:0] error_code;
    logic       covered;

    modport source (
        output valid, accepted, error_code, covered,
        input  ready
    );
    modport sink (
        input  valid, accepted, error_code, covered,
        output ready
    );
endinterface

// ----- rtl/artc_ram.sv -----
// ----------------------------------------------------------------------------
// artc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module artc_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/as_range_table_check_core.sv -----
// ----------------------------------------------------------------------------
// as_range_table_check_core
// Table of single numbers, inclusive ranges and an inherit marker, with
// checked insert, cover query and clear requests.
// ----------------------------------------------------------------------------
// One request at a time. An insert or cover query on a table of N stored
// entries walks them through the table RAM's single read port, one entry per
// cycle, and stops early on the first overlap or match. Clear, unknown
// requests, inherit conflicts and requests on an empty table skip the walk
// and go from the check step straight to the done step.
// The result sits in an output register, so the next request is taken while
// it waits; a result that is still waiting holds the following one in its
// last step. Up to MAX_ENTRIES entries are held.
module as_range_table_check_core #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    artc_req_if.sink   i_req,
    artc_rsp_if.source o_rsp
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = $bits(artc_pkg::t_entry);

    artc_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_dv, n_dv;
    logic             r_first_inh, n_first_inh;
    logic [1:0]       r_req, n_req;
    logic [1:0]       r_kind, n_kind;
    logic [31:0]      r_lo, n_lo;
    logic [31:0]      r_hi, n_hi;
    artc_pkg::t_rsp   r_res, n_res;
    artc_pkg::t_rsp   r_out, n_out;
    logic             r_ovalid, n_ovalid;

    logic             accept;
    logic [1:0]       in_kind;
    logic             we;
    logic             re;
    logic [AW-1:0]    waddr;
    artc_pkg::t_entry wentry;
    logic [EW-1:0]    rdata;
    artc_pkg::t_entry rd;
    logic             hit;
    logic             full;

    artc_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wentry),
        .i_re    (re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    assign i_req.ready      = (r_state == artc_pkg::ST_IDLE);
    assign accept           = i_req.valid && i_req.ready;
    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.accepted   = r_out.accepted;
    assign o_rsp.error_code = r_out.error_code;
    assign o_rsp.covered    = r_out.covered;

    assign in_kind = (i_req.entry_kind > artc_pkg::KIND_INHERIT) ?
                     artc_pkg::KIND_INHERIT : i_req.entry_kind;
    assign rd      = artc_pkg::t_entry'(rdata);
    assign full    = (r_count >= CW'(MAX_ENTRIES));
    assign waddr   = r_count[AW-1:0];
    assign wentry  = '{kind: r_kind, low: r_lo, high: r_hi};

    always_comb begin
        hit = 1'b0;
        if (r_dv && rd.kind != artc_pkg::KIND_INHERIT) begin
            if (r_req == artc_pkg::REQ_COVER) begin
                hit = (r_lo >= rd.low) && (r_lo <= rd.high);
            end else begin
                hit = !((r_hi < rd.low) || (r_lo > rd.high));
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_dv        = 1'b0;
        n_first_inh = r_first_inh;
        n_req       = r_req;
        n_kind      = r_kind;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_res       = r_res;
        n_out       = r_out;
        n_ovalid    = r_ovalid;
        we          = 1'b0;
        re          = 1'b0;

        if (o_rsp.valid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            artc_pkg::ST_IDLE: begin
                if (accept) begin
                    n_req = i_req.req_type;
                    n_kind = in_kind;
                    n_lo = i_req.num_low;
                    n_hi = i_req.num_high;
                    if (i_req.req_type == artc_pkg::REQ_INSERT) begin
                        if (in_kind == artc_pkg::KIND_SINGLE) begin
                            n_hi = i_req.num_low;
                        end else if (in_kind == artc_pkg::KIND_INHERIT) begin
                            n_lo = '0;
                            n_hi = '0;
                        end
                    end
                    n_state = artc_pkg::ST_CHECK;
                end
            end
            artc_pkg::ST_CHECK: begin
                n_res = '0;
                n_idx = '0;
                n_state = artc_pkg::ST_DONE;
                case (r_req)
                    artc_pkg::REQ_INSERT: begin
                        if (r_count != '0 &&
                            (r_kind == artc_pkg::KIND_INHERIT || r_first_inh)) begin
                            n_res.error_code = artc_pkg::ERR_INHERIT;
                        end else if (r_count == '0) begin
                            we = 1'b1;
                            n_count = r_count + CW'(1);
                            n_first_inh = (r_kind == artc_pkg::KIND_INHERIT);
                            n_res.accepted = 1'b1;
                        end else begin
                            n_state = artc_pkg::ST_SCAN;
                        end
                    end
                    artc_pkg::REQ_COVER: begin
                        if (r_count != '0) begin
                            n_state = artc_pkg::ST_SCAN;
                        end
                    end
                    artc_pkg::REQ_CLEAR: begin
                        n_count = '0;
                        n_res.accepted = 1'b1;
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
            end
            artc_pkg::ST_SCAN: begin
                re = (r_idx != r_count);
                n_dv = re;
                if (re) begin
                    n_idx = r_idx + CW'(1);
                end
                if (hit) begin
                    n_res = '0;
                    if (r_req == artc_pkg::REQ_COVER) begin
                        n_res.covered = 1'b1;
                    end else begin
                        n_res.error_code = artc_pkg::ERR_OVERLAP;
                    end
                    n_state = artc_pkg::ST_DONE;
                end else if (r_idx == r_count) begin
                    n_res = '0;
                    if (r_req == artc_pkg::REQ_INSERT) begin
                        if (full) begin
                            n_res.error_code = artc_pkg::ERR_FULL;
                        end else begin
                            we = 1'b1;
                            n_count = r_count + CW'(1);
                            n_res.accepted = 1'b1;
                        end
                    end
                    n_state = artc_pkg::ST_DONE;
                end
            end
            artc_pkg::ST_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_out = r_res;
                    n_state = artc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = artc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= artc_pkg::ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_dv        <= 1'b0;
            r_first_inh <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_dv        <= n_dv;
            r_first_inh <= n_first_inh;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_kind <= n_kind;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_res  <= n_res;
        r_out  <= n_out;
    end

endmodule
